/* sv/fst_pkg.sv */
// ----------------------------------------------------------------------------
// fst_pkg
// Shared widths, operation and status codes and sequencer states for the
// flow slot table.
// ----------------------------------------------------------------------------
package fst_pkg;

   localparam int MODE_W   = 2;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int ROW_W    = 6;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_LOOKUP  = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_MISS = 2'd2,
      ST_RSVD = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_ALLOC  = 4'b0010,
      S_SEARCH = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

endpackage

/* sv/flow_slot_table.sv */
// throughput: one request at a time; the key memory is read one slot per
// cycle, and the free-slot scan walks the used bits one slot per cycle
// reset clears all used bits at once; the key memory is not cleared, a key
// is only compared while its slot is marked used
// ----------------------------------------------------------------------------
// flow_slot_table
// Associative table of flows keyed by a cookie: allocate the lowest free
// slot, look up or release the lowest used slot holding a cookie.
// ----------------------------------------------------------------------------
module flow_slot_table #(
   parameter int SLOT_COUNT = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fst_pkg::MODE_W-1:0]    req_mode,
   input  logic [fst_pkg::KEY_W-1:0]     req_cookie,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fst_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fst_pkg::ROW_W-1:0]     rsp_row_index
);
   import fst_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOT_COUNT);

   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [KEY_W-1:0]      cookie_ff, cookie_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   status_type            res_status_ff, res_status_in;
   logic [ROW_W-1:0]      res_row_ff, res_row_in;
   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ROW_W-1:0]      rsp_row_ff, rsp_row_in;

   logic [KEY_W-1:0]      key_mem [SLOT_COUNT];
   logic [KEY_W-1:0]      key_rd_ff;

   logic                  req_take;
   logic                  rd_en;
   logic                  wr_en;
   logic [IDX_W-1:0]      slot_idx;
   logic                  alloc_take;
   logic                  search_hit;
   logic                  out_free;

   assign req_take   = req_valid && !req_stall;
   assign slot_idx   = idx_ff[IDX_W-1:0];
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign alloc_take = (state_ff == S_ALLOC) && (idx_ff != CNT_END) && !used_ff[slot_idx];
   assign search_hit = (state_ff == S_SEARCH) && cmp_vld_ff && used_ff[cmp_idx_ff]
                       && (key_rd_ff == cookie_ff);
   assign wr_en      = alloc_take;
   assign rd_en      = (state_ff == S_SEARCH) && !search_hit && (idx_ff != CNT_END);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      cookie_in     = cookie_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      res_status_in = res_status_ff;
      res_row_in    = res_row_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               mode_in    = mode_type'(req_mode);
               cookie_in  = req_cookie;
               idx_in     = '0;
               cmp_vld_in = 1'b0;
               case (mode_type'(req_mode))
                  MODE_ALLOC:                state_in = S_ALLOC;
                  MODE_LOOKUP, MODE_RELEASE: state_in = S_SEARCH;
                  default: begin
                     res_status_in = ST_MISS;
                     res_row_in    = '0;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            if (idx_ff == CNT_END) begin
               res_status_in = ST_FULL;
               res_row_in    = '0;
               state_in      = S_DONE;
            end else if (alloc_take) begin
               used_in[slot_idx] = 1'b1;
               res_status_in     = ST_OK;
               res_row_in        = ROW_W'(int'(slot_idx) + 1);
               state_in          = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SEARCH: begin
            if (search_hit) begin
               if (mode_ff == MODE_RELEASE) begin
                  used_in[cmp_idx_ff] = 1'b0;
               end
               res_status_in = ST_OK;
               res_row_in    = ROW_W'(int'(cmp_idx_ff) + 1);
               state_in      = S_DONE;
            end else if (idx_ff == CNT_END && !cmp_vld_ff) begin
               res_status_in = ST_MISS;
               res_row_in    = '0;
               state_in      = S_DONE;
            end else if (rd_en) begin
               // read of the next slot overlaps the compare of this one
               cmp_vld_in = 1'b1;
               cmp_idx_in = slot_idx;
               idx_in     = idx_ff + 1'b1;
            end else begin
               cmp_vld_in = 1'b0;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_row_in    = res_row_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      cookie_ff     <= cookie_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_row_ff    <= res_row_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
   end

   // key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[slot_idx] <= cookie_ff;
      end
      if (rd_en) begin
         key_rd_ff <= key_mem[slot_idx];
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_row_index = rsp_row_ff;

   a_alloc_marks_used: assert property (@(posedge clock) disable iff (reset)
      alloc_take |=> used_ff[$past(slot_idx)])
      else $error("allocated slot not marked used");

   a_release_frees: assert property (@(posedge clock) disable iff (reset)
      (search_hit && mode_ff == MODE_RELEASE) |=> !used_ff[$past(cmp_idx_ff)])
      else $error("released slot still marked used");

   a_fail_no_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_row_ff == '0))
      else $error("failed response carries a row index");

endmodule
